/* hdl/atai_pkg.sv */
// shared constants, register codes and item flag type for the address to index block
package atai_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int ADDR_WIDTH_DEF  = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARRAY_BASE    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_COUNT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ELEMENT_SIZE  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARRAY_SPAN    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NULL_INDEX    = 3'd4;

   localparam logic [DATA_WIDTH-1:0] NULL_INDEX_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic nullable;
      logic zero_addr;
      logic in_range;
   } item_flags_type;

endpackage

/* hdl/atai_geom.sv */
// geometry check of the configured array, two register stages behind the config registers
module atai_geom #(
   parameter int ADDR_WIDTH = atai_pkg::ADDR_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic [atai_pkg::DATA_WIDTH-1:0] array_base,
   input  logic [atai_pkg::DATA_WIDTH-1:0] element_count,
   input  logic [atai_pkg::DATA_WIDTH-1:0] element_size,
   input  logic [atai_pkg::DATA_WIDTH-1:0] array_span,
   output logic                            geom_ok
);
   import atai_pkg::*;

   localparam int DW = (ADDR_WIDTH < DATA_WIDTH) ? ADDR_WIDTH : DATA_WIDTH;
   localparam logic [63:0] LIM = (64'd1 << ADDR_WIDTH) - 64'd1;

   logic [63:0] base_w;
   logic [63:0] span_w;
   logic [63:0] size_w;
   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic        nonzero_ff;
   logic        nonzero_in;
   logic        geom_ok_ff;
   logic        geom_ok_in;

   always_comb begin
      base_w     = 64'(array_base[DW-1:0]);
      span_w     = 64'(array_span[DW-1:0]);
      size_w     = 64'(element_size[DW-1:0]);
      prod_in    = 64'(element_count) * size_w;
      nonzero_in = (base_w != 64'd0) && (element_count != '0) &&
                   (size_w != 64'd0) && (span_w != 64'd0);
      geom_ok_in = nonzero_ff && ((prod_ff & ~LIM) == 64'd0) && (span_w == prod_ff) &&
                   (span_w <= (LIM - base_w));
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      nonzero_ff <= nonzero_in;
      geom_ok_ff <= geom_ok_in;
   end

   assign geom_ok = geom_ok_ff;

endmodule

/* hdl/atai_front.sv */
// entry stage: offset from base and range flags of one lookup
module atai_front #(
   parameter int W = atai_pkg::DATA_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_cmd,
   input  logic [atai_pkg::DATA_WIDTH-1:0] in_address,
   input  logic [atai_pkg::DATA_WIDTH-1:0] array_base,
   input  logic [atai_pkg::DATA_WIDTH-1:0] array_span,
   output logic                            out_valid,
   input  logic                            out_ready,
   output atai_pkg::item_flags_type        out_flags,
   output logic [W-1:0]                    out_delta
);
   import atai_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   item_flags_type flags_ff;
   item_flags_type flags_in;
   logic [W-1:0]   delta_ff;
   logic [W-1:0]   delta_in;
   logic [W-1:0]   addr_c;
   logic [W-1:0]   base_c;

   always_comb begin
      addr_c             = in_address[W-1:0];
      base_c             = array_base[W-1:0];
      delta_in           = addr_c - base_c;
      flags_in.nullable  = in_cmd;
      flags_in.zero_addr = (addr_c == '0);
      flags_in.in_range  = (addr_c >= base_c) && (delta_in < array_span[W-1:0]);
      in_ready           = !valid_ff || out_ready;
      valid_in           = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flags_ff <= flags_in;
         delta_ff <= delta_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_delta = delta_ff;

endmodule

/* hdl/atai_div_cell.sv */
// one restoring division cell: one quotient bit per cell, item held while the next cell is full
module atai_div_cell #(
   parameter int W = atai_pkg::DATA_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  atai_pkg::item_flags_type in_flags,
   input  logic [W-1:0]             in_num,
   input  logic [W-1:0]             in_rem,
   input  logic [W-1:0]             in_quo,
   input  logic [W-1:0]             divisor,
   output logic                     out_valid,
   input  logic                     out_ready,
   output atai_pkg::item_flags_type out_flags,
   output logic [W-1:0]             out_num,
   output logic [W-1:0]             out_rem,
   output logic [W-1:0]             out_quo
);
   import atai_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   item_flags_type flags_ff;
   logic [W-1:0]   num_ff;
   logic [W-1:0]   num_in;
   logic [W-1:0]   rem_ff;
   logic [W-1:0]   rem_in;
   logic [W-1:0]   quo_ff;
   logic [W-1:0]   quo_in;
   logic [W:0]     trial;
   logic [W:0]     diff;
   logic           fits;

   always_comb begin
      // bring down the next dividend bit and try the subtract
      trial    = {in_rem, in_num[W-1]};
      diff     = trial - {1'b0, divisor};
      fits     = (trial >= {1'b0, divisor});
      rem_in   = fits ? diff[W-1:0] : trial[W-1:0];
      num_in   = {in_num[W-2:0], 1'b0};
      quo_in   = {in_quo[W-2:0], fits};
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         flags_ff <= in_flags;
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(quo_ff) && $stable(rem_ff))
      else $error("cell lost or changed a blocked item");

   a_fill_on_accept: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff && (quo_ff[0] == $past(fits)))
      else $error("cell did not capture the accepted item");

endmodule

/* hdl/address_to_array_index.sv */
// top level: address to array element index translation
//
// Usage:
//   req_ channel carries one lookup (req_cmd, req_address); an item is taken when
//   req_valid and req_ready are both high. rsp_ channel returns one result per lookup
//   (rsp_ok, rsp_index) in the order of the requests, taken on rsp_valid and rsp_ready.
//   csr_ channel writes the geometry registers by index (base, count, size, span,
//   null index); csr_ready is always high. Write them only while no lookup is in flight.
// Pipeline: one entry stage, one restoring division cell per quotient bit, with
//   DW = min(ADDR_WIDTH, 32) quotient bits, and one output register.
// Throughput: one lookup per cycle while rsp_ready is high; every cell holds one item.
// After a register write, geometry validity is recomputed through the atai_geom registers.
// Reset: all pipeline valid bits clear, registers take their reset values
//   (null index all ones, the rest zero).
// Stall: when rsp_ready is low, items pack up cell by cell; req_ready drops only when
//   every stage holds an item.
module address_to_array_index #(
   parameter int ADDR_WIDTH = atai_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic [atai_pkg::DATA_WIDTH-1:0]      req_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_ok,
   output logic [atai_pkg::DATA_WIDTH-1:0]      rsp_index,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [atai_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [atai_pkg::DATA_WIDTH-1:0]      csr_wdata
);
   import atai_pkg::*;

   localparam int DW = (ADDR_WIDTH < DATA_WIDTH) ? ADDR_WIDTH : DATA_WIDTH;

   logic [DATA_WIDTH-1:0] array_base_ff;
   logic [DATA_WIDTH-1:0] element_count_ff;
   logic [DATA_WIDTH-1:0] element_size_ff;
   logic [DATA_WIDTH-1:0] array_span_ff;
   logic [DATA_WIDTH-1:0] null_index_ff;
   logic                  geom_ok;

   logic                  link_valid [0:DW];
   logic                  link_ready [0:DW];
   item_flags_type        link_flags [0:DW];
   logic [DW-1:0]         link_num   [0:DW];
   logic [DW-1:0]         link_rem   [0:DW];
   logic [DW-1:0]         link_quo   [0:DW];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_ok_ff;
   logic                  rsp_ok_in;
   logic [DATA_WIDTH-1:0] rsp_index_ff;
   logic [DATA_WIDTH-1:0] rsp_index_in;
   logic [DATA_WIDTH-1:0] quotient;
   logic                  hit;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         array_base_ff    <= '0;
         element_count_ff <= '0;
         element_size_ff  <= '0;
         array_span_ff    <= '0;
         null_index_ff    <= NULL_INDEX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ARRAY_BASE: begin
               array_base_ff <= csr_wdata;
            end
            CSR_ELEMENT_COUNT: begin
               element_count_ff <= csr_wdata;
            end
            CSR_ELEMENT_SIZE: begin
               element_size_ff <= csr_wdata;
            end
            CSR_ARRAY_SPAN: begin
               array_span_ff <= csr_wdata;
            end
            CSR_NULL_INDEX: begin
               null_index_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   atai_geom #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_geom (
      .clock         (clock),
      .array_base    (array_base_ff),
      .element_count (element_count_ff),
      .element_size  (element_size_ff),
      .array_span    (array_span_ff),
      .geom_ok       (geom_ok)
   );

   atai_front #(
      .W (DW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_cmd     (req_cmd),
      .in_address (req_address),
      .array_base (array_base_ff),
      .array_span (array_span_ff),
      .out_valid  (link_valid[0]),
      .out_ready  (link_ready[0]),
      .out_flags  (link_flags[0]),
      .out_delta  (link_num[0])
   );

   assign link_rem[0] = '0;
   assign link_quo[0] = '0;

   for (genvar i = 0; i < DW; i++) begin : g_cell
      atai_div_cell #(
         .W (DW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_flags  (link_flags[i]),
         .in_num    (link_num[i]),
         .in_rem    (link_rem[i]),
         .in_quo    (link_quo[i]),
         .divisor   (element_size_ff[DW-1:0]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_flags (link_flags[i+1]),
         .out_num   (link_num[i+1]),
         .out_rem   (link_rem[i+1]),
         .out_quo   (link_quo[i+1])
      );
   end

   assign link_ready[DW] = !rsp_valid_ff || rsp_ready;

   // result stage
   always_comb begin
      quotient       = DATA_WIDTH'(link_quo[DW]);
      hit            = geom_ok && link_flags[DW].in_range && (link_rem[DW] == '0) &&
                       (quotient < element_count_ff);
      if (link_flags[DW].zero_addr) begin
         rsp_ok_in    = link_flags[DW].nullable && geom_ok;
         rsp_index_in = rsp_ok_in ? null_index_ff : '0;
      end else begin
         rsp_ok_in    = hit;
         rsp_index_in = hit ? quotient : '0;
      end
      rsp_valid_in   = link_ready[DW] ? link_valid[DW] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_valid[DW] && link_ready[DW]) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_index_ff <= rsp_index_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_index = rsp_index_ff;

   a_reject_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_index == '0)
      else $error("rejected item carries a nonzero index");

   a_backpressure_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked while the output is free");

   a_zero_strict_rejected: assert property (@(posedge clock) disable iff (reset)
      link_valid[DW] && link_flags[DW].zero_addr && !link_flags[DW].nullable |-> !rsp_ok_in)
      else $error("strict lookup of a zero address accepted");

endmodule
